@@ rtl/pmq_pkg.sv @@
// Shared constants, types and helper functions of the priority message queues.
package pmq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_LEVELS = 4;
  localparam int DATA_WIDTH  = 64;

  localparam int STORE_SIZE = QUEUE_DEPTH * PRIO_LEVELS;
  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int LVL_W      = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CNT_W      = $clog2(PRIO_LEVELS * (QUEUE_DEPTH - 1) + 1);

  localparam int ID_W      = 16;
  localparam int TIME_W    = 32;
  localparam int PRIO_W    = 3;
  localparam int XDATA_W   = 64;
  localparam int PEND_W    = 6;
  localparam int PEND_MAX  = 63;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_PRIO = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NO_MSG   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]       src;
    logic [ID_W-1:0]       dst;
    logic [DATA_WIDTH-1:0] data;
    logic [TIME_W-1:0]     stamp;
  } msg_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [LVL_W-1:0] level;
  } ptr_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  tail;
    logic              empty;
    logic              full;
    logic [CNT_W-1:0]  pending_after;
  } ptr_stat_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] level,
                                                  input logic [IDX_W-1:0] idx);
    return ADDR_W'(32'(level) * QUEUE_DEPTH + 32'(idx));
  endfunction

  function automatic logic [PEND_W-1:0] sat_pending(input logic [CNT_W-1:0] c);
    if (32'(c) > PEND_MAX) begin
      return PEND_W'(PEND_MAX);
    end
    return PEND_W'(c);
  endfunction

endpackage

@@ rtl/priority_message_queues.sv @@
// Top level of the priority message queues: command port, scan sequencer and result register.
// A send is taken at the transfer, then checked and written in the send state.
// A receive visits the levels from the highest down: an empty level is skipped, and each
// non-empty level costs one read of its head from the message store and one compare.
// The result shows on out_valid for one cycle right after the last working cycle, and the next
// transfer can already be taken in that cycle. Reset (rst_n low, synchronous) empties every queue.
module priority_message_queues (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_send_src,
  input  logic [15:0] in_send_dst,
  input  logic [2:0]  in_send_prio,
  input  logic [63:0] in_send_data,
  input  logic [31:0] in_send_time,
  input  logic [15:0] in_recv_module,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_msg_src,
  output logic [15:0] out_msg_dst,
  output logic [2:0]  out_msg_prio,
  output logic [63:0] out_msg_data,
  output logic [31:0] out_msg_time,
  output logic [5:0]  out_pending_count
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEND = 4'b0010,
    ST_RD   = 4'b0100,
    ST_CHK  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Item captured at the transfer.
  logic [pmq_pkg::ID_W-1:0]       src_r;
  logic [pmq_pkg::ID_W-1:0]       dst_r;
  logic [pmq_pkg::PRIO_W-1:0]     prio_r;
  logic [pmq_pkg::DATA_WIDTH-1:0] data_r;
  logic [pmq_pkg::TIME_W-1:0]     time_r;
  logic [pmq_pkg::ID_W-1:0]       mod_r;

  // Level under inspection during a receive scan, highest first.
  logic [pmq_pkg::LVL_W-1:0]      lvl_r, lvl_nxt;

  pmq_pkg::ptr_cmd_t              cmd;
  pmq_pkg::ptr_stat_t             stat;
  logic                           wr_en;
  logic [pmq_pkg::ADDR_W-1:0]     wr_addr;
  logic [pmq_pkg::ADDR_W-1:0]     rd_addr;
  pmq_pkg::msg_t                  wr_msg;
  pmq_pkg::msg_t                  rd_msg;

  // Result of the current cycle, loaded into the output register when res_valid is set.
  logic                           res_valid;
  pmq_pkg::status_t               res_status;
  pmq_pkg::msg_t                  res_msg;
  logic [pmq_pkg::PRIO_W-1:0]     res_prio;
  logic                           prio_ok;
  logic                           head_match;
  logic                           accept;

  logic                           out_valid_r;
  pmq_pkg::status_t               out_status_r;
  logic [pmq_pkg::ID_W-1:0]       out_src_r;
  logic [pmq_pkg::ID_W-1:0]       out_dst_r;
  logic [pmq_pkg::PRIO_W-1:0]     out_prio_r;
  logic [pmq_pkg::XDATA_W-1:0]    out_data_r;
  logic [pmq_pkg::TIME_W-1:0]     out_time_r;
  logic [pmq_pkg::PEND_W-1:0]     out_pend_r;

  pmq_ptrs u_ptrs (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  pmq_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_msg  (wr_msg),
    .rd_addr (rd_addr),
    .rd_msg  (rd_msg)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // A send with a level number the block does not have is rejected without effect.
  assign prio_ok = (32'(prio_r) < pmq_pkg::PRIO_LEVELS);

  // A head is taken when it targets the receiver or is a broadcast (target zero).
  assign head_match = (rd_msg.dst == mod_r) || (rd_msg.dst == '0);

  assign wr_msg.src   = src_r;
  assign wr_msg.dst   = dst_r;
  assign wr_msg.data  = data_r;
  assign wr_msg.stamp = time_r;
  assign wr_addr      = pmq_pkg::slot_addr(cmd.level, stat.tail);
  assign rd_addr      = pmq_pkg::slot_addr(lvl_r, stat.head);

  always_comb begin
    state_nxt  = state_r;
    lvl_nxt    = lvl_r;
    cmd.push   = 1'b0;
    cmd.pop    = 1'b0;
    cmd.level  = lvl_r;
    wr_en      = 1'b0;
    res_valid  = 1'b0;
    res_status = pmq_pkg::STAT_OK;
    res_msg    = '0;
    res_prio   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = in_func ? ST_RD : ST_SEND;
          lvl_nxt   = pmq_pkg::LVL_W'(pmq_pkg::PRIO_LEVELS - 1);
        end
      end
      ST_SEND: begin
        // The level select only matters when the priority is in range.
        cmd.level = pmq_pkg::LVL_W'(prio_r);
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
        if (!prio_ok) begin
          res_status = pmq_pkg::STAT_BAD_PRIO;
        end else if (stat.full) begin
          res_status = pmq_pkg::STAT_FULL;
        end else begin
          cmd.push = 1'b1;
          wr_en    = 1'b1;
        end
      end
      ST_RD: begin
        // An empty level is skipped at once; otherwise its head is being read.
        if (stat.empty) begin
          if (lvl_r == '0) begin
            res_valid  = 1'b1;
            res_status = pmq_pkg::STAT_NO_MSG;
            state_nxt  = ST_IDLE;
          end else begin
            lvl_nxt = lvl_r - 1'b1;
          end
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (head_match) begin
          cmd.pop   = 1'b1;
          res_valid = 1'b1;
          res_msg   = rd_msg;
          res_prio  = pmq_pkg::PRIO_W'(lvl_r);
          state_nxt = ST_IDLE;
        end else if (lvl_r == '0) begin
          res_valid  = 1'b1;
          res_status = pmq_pkg::STAT_NO_MSG;
          state_nxt  = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= res_valid;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      src_r  <= in_send_src;
      dst_r  <= in_send_dst;
      prio_r <= in_send_prio;
      data_r <= in_send_data[pmq_pkg::DATA_WIDTH-1:0];
      time_r <= in_send_time;
      mod_r  <= in_recv_module;
    end
    if (res_valid) begin
      out_status_r <= res_status;
      out_src_r    <= res_msg.src;
      out_dst_r    <= res_msg.dst;
      out_prio_r   <= res_prio;
      out_data_r   <= pmq_pkg::XDATA_W'(res_msg.data);
      out_time_r   <= res_msg.stamp;
      out_pend_r   <= pmq_pkg::sat_pending(stat.pending_after);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_msg_src       = out_src_r;
  assign out_msg_dst       = out_dst_r;
  assign out_msg_prio      = out_prio_r;
  assign out_msg_data      = out_data_r;
  assign out_msg_time      = out_time_r;
  assign out_pending_count = out_pend_r;

endmodule

@@ rtl/pmq_store.sv @@
// Message storage: one slot per queue entry, one write and one registered read port.
module pmq_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [pmq_pkg::ADDR_W-1:0]    wr_addr,
  input  pmq_pkg::msg_t                 wr_msg,
  input  logic [pmq_pkg::ADDR_W-1:0]    rd_addr,
  output pmq_pkg::msg_t                 rd_msg
);

  pmq_pkg::msg_t mem [pmq_pkg::STORE_SIZE];
  pmq_pkg::msg_t rd_msg_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_msg;
    end
    rd_msg_r <= mem[rd_addr];
  end

  assign rd_msg = rd_msg_r;

endmodule

@@ rtl/pmq_ptrs.sv @@
// Ring pointers of every priority level and the running count of pending messages.
module pmq_ptrs (
  input  logic                clk,
  input  logic                rst_n,
  input  pmq_pkg::ptr_cmd_t   cmd,
  output pmq_pkg::ptr_stat_t  stat
);

  logic [pmq_pkg::IDX_W-1:0] head_r [pmq_pkg::PRIO_LEVELS];
  logic [pmq_pkg::IDX_W-1:0] tail_r [pmq_pkg::PRIO_LEVELS];
  logic [pmq_pkg::CNT_W-1:0] cnt_r;
  logic [pmq_pkg::CNT_W-1:0] cnt_nxt;

  always_comb begin
    stat.head  = head_r[cmd.level];
    stat.tail  = tail_r[cmd.level];
    stat.empty = (stat.head == stat.tail);
    stat.full  = (pmq_pkg::next_idx(stat.tail) == stat.head);
    if (cmd.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    stat.pending_after = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pmq_pkg::PRIO_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      cnt_r <= '0;
    end else begin
      if (cmd.push) begin
        tail_r[cmd.level] <= pmq_pkg::next_idx(stat.tail);
      end
      if (cmd.pop) begin
        head_r[cmd.level] <= pmq_pkg::next_idx(stat.head);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/pmq_checker.sv @@
// Port-level checker of the priority message queues and its bind statement.
module pmq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_func,
  input logic [15:0] in_send_src,
  input logic [15:0] in_send_dst,
  input logic [2:0]  in_send_prio,
  input logic [63:0] in_send_data,
  input logic [31:0] in_send_time,
  input logic [15:0] in_recv_module,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [15:0] out_msg_src,
  input logic [15:0] out_msg_dst,
  input logic [2:0]  out_msg_prio,
  input logic [63:0] out_msg_data,
  input logic [31:0] out_msg_time,
  input logic [5:0]  out_pending_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after a transfer");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pmq_pkg::STAT_OK) |->
      (out_msg_src == '0 && out_msg_dst == '0 && out_msg_prio == '0 &&
       out_msg_data == '0 && out_msg_time == '0))
    else $error("message fields not zero on a failed item");

  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_pending_count) <=
                   pmq_pkg::PRIO_LEVELS * (pmq_pkg::QUEUE_DEPTH - 1)))
    else $error("pending count beyond queue capacity");

endmodule

bind priority_message_queues pmq_checker u_pmq_checker (.*);
